@@ hw/rtl/gpu_command_packet_framer_macros.svh @@
// Assertion macros shared by the framer RTL.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef GPU_COMMAND_PACKET_FRAMER_MACROS_SVH
`define GPU_COMMAND_PACKET_FRAMER_MACROS_SVH

// same-cycle implication
`define GCPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GCPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gcpf_pkg.sv @@
// Shared types and constants for the GP0 command packet framer.
// No dependencies; imported by all framer modules.
package gcpf_pkg;

    localparam int COUNT_BITS_DEF = 20;
    localparam int IDX_W          = 20;
    localparam int KIND_W         = 5;
    localparam int TOTAL_W        = 4;
    localparam int VRAM_TOT_W     = 18;
    localparam int ENV_W          = 24;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    // result roles
    localparam logic [2:0] ROLE_SINGLE  = 3'd0;
    localparam logic [2:0] ROLE_PACKET  = 3'd1;
    localparam logic [2:0] ROLE_LAST    = 3'd2;
    localparam logic [2:0] ROLE_INVALID = 3'd3;
    localparam logic [2:0] ROLE_RESET   = 3'd4;

    // decode classes
    localparam logic [2:0] CLS_PACKET  = 3'd0;
    localparam logic [2:0] CLS_NOP     = 3'd1;
    localparam logic [2:0] CLS_IRQ     = 3'd2;
    localparam logic [2:0] CLS_ENV     = 3'd3;
    localparam logic [2:0] CLS_INVALID = 3'd4;

    localparam logic [KIND_W-1:0] KIND_NONE       = 5'd0;
    localparam logic [KIND_W-1:0] KIND_VRAM_WRITE = 5'd2;
    localparam logic [KIND_W-1:0] KIND_MONO_POLY  = 5'd14;
    localparam logic [KIND_W-1:0] KIND_SHAD_POLY  = 5'd16;

    localparam logic [31:0] LINE_END      = 32'h5000_5000;
    localparam logic [31:0] LINE_END_MASK = 32'hF000_F000;

    typedef struct packed {
        logic                  action;
        logic [31:0]           word;
        logic [2:0]            cls;
        logic [KIND_W-1:0]     kind;
        logic [TOTAL_W-1:0]    total;
        logic [2:0]            flags;
        logic [2:0]            env_target;
        logic [ENV_W-1:0]      env_value;
        logic [VRAM_TOT_W-1:0] vram_total;
        logic                  line_end;
    } gcpf_item_t;

endpackage

@@ hw/rtl/gpu_command_packet_framer.sv @@
// Top level of the GP0 command packet framer: decode front, queue, framing back end.
// Depends on gcpf_pkg, gcpf_front, gcpf_queue, gcpf_back.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser = action, s_tdata = word
//  m_*     | out | m_tvalid/m_tready  | m_tuser = role, m_tdata = result fields
//
// One word per cycle sustained while m_tready stays high; a request is written into the queue when
// accepted and then moves into the output register, from which it drives m_*.
// Decode needs no state, so the back end's packet counter and the output register set the pace.
// rst_n clears the queue, the packet state, the irq flag and the output valid.
// Either side may stall: the two-entry queue lets input continue while output waits.
module gpu_command_packet_framer
    import gcpf_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // kind[4:0] semi[5] tex[7:6] idx[27:8] data[59:28]
                                   // env_target[62:60] env_value[86:63] irq[87]
    output logic [2:0]  m_tuser    // [2:0] role
);

    gcpf_item_t dec_item;
    gcpf_item_t head_item;
    logic       q_full;
    logic       head_valid;
    logic       pop;

    assign s_tready = !q_full;

    gcpf_front u_front
    (
        .action (s_tuser),
        .word   (s_tdata),
        .item   (dec_item)
    );

    gcpf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid && !q_full),
        .push_item  (dec_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    gcpf_back #(.COUNT_BITS(COUNT_BITS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

@@ hw/rtl/gcpf_front.sv @@
// Front end: classifies each incoming word by its opcode, independent of packet state.
// Depends on gcpf_pkg.
module gcpf_front
    import gcpf_pkg::*;
(
    input  logic       action,
    input  logic [31:0] word,
    output gcpf_item_t item
);

    logic [7:0]  op;
    logic        semi;
    logic [1:0]  rawtex;
    logic [18:0] area;

    assign op     = word[31:24];
    assign semi   = op[1];
    assign rawtex = op[0] ? 2'd2 : 2'd1;
    assign area   = 19'(word[9:0]) * 19'(word[24:16]);

    always_comb
    begin
        item            = '0;
        item.action     = action;
        item.word       = word;
        item.vram_total = VRAM_TOT_W'(19'd3 + 19'(area[18:1]) + 19'(area[0]));
        item.line_end   = (word & LINE_END_MASK) == LINE_END;
        item.cls        = CLS_INVALID;
        if (op == 8'h02)
        begin
            item.kind = 5'd1; item.total = 4'd3;
        end
        else if (op == 8'hA0)
        begin
            item.kind = 5'd2; item.total = 4'd3;
        end
        else if (op == 8'hC0)
        begin
            item.kind = 5'd3; item.total = 4'd3;
        end
        else if (op == 8'h80)
        begin
            item.kind = 5'd4; item.total = 4'd4;
        end
        else if (op[7:5] == 3'b001)
        begin
            // polygons: op[4] shaded, op[2] textured, op[3] quad
            case ({op[4], op[2]})
                2'b00:
                begin
                    item.total = op[3] ? 4'd5 : 4'd4;
                    item.flags = {2'd0, semi};
                    item.kind  = 5'd5 + 5'(op[3]);
                end
                2'b01:
                begin
                    item.total = op[3] ? 4'd9 : 4'd7;
                    item.flags = {rawtex, semi};
                    item.kind  = 5'd7 + 5'(op[3]);
                end
                2'b10:
                begin
                    item.total = op[3] ? 4'd8 : 4'd6;
                    item.flags = {2'd0, semi};
                    item.kind  = 5'd9 + 5'(op[3]);
                end
                default:
                begin
                    item.total = op[3] ? 4'd12 : 4'd9;
                    item.flags = {2'd1, semi};
                    item.kind  = 5'd11 + 5'(op[3]);
                end
            endcase
        end
        else if (op[7:5] == 3'b010)
        begin
            if (op[2] == 1'b0 && op[0] == 1'b0)
            begin
                item.flags = {2'd0, semi};
                item.total = op[4] ? 4'd4 : 4'd3;
                item.kind  = 5'd13 + {3'd0, op[4], 1'b0} + 5'(op[3]);
            end
        end
        else if (op[7:5] == 3'b011)
        begin
            if (op[2])
            begin
                item.total = (op[4:3] == 2'd0) ? 4'd4 : 4'd3;
                item.flags = {rawtex, semi};
                item.kind  = 5'd21 + 5'(op[4:3]);
            end
            else if (!op[0])
            begin
                item.total = (op[4:3] == 2'd0) ? 4'd3 : 4'd2;
                item.flags = {2'd0, semi};
                item.kind  = 5'd17 + 5'(op[4:3]);
            end
        end

        if (item.kind != KIND_NONE)
            item.cls = CLS_PACKET;
        else if (op == 8'h00 || op == 8'h01)
            item.cls = CLS_NOP;
        else if (op == 8'h1F)
            item.cls = CLS_IRQ;
        else if (op >= 8'hE1 && op <= 8'hE6)
        begin
            item.cls        = CLS_ENV;
            item.env_target = 3'(op - 8'hE0);
            if (op == 8'hE1)
                item.env_value = {10'd0, word[13:0]};
            else if (op == 8'hE6)
                item.env_value = {22'd0, word[1:0]};
            else
                item.env_value = word[23:0];
        end
    end

endmodule

@@ hw/rtl/gcpf_queue.sv @@
// Two-entry queue between the decode front and the packet back end.
// Depends on gcpf_pkg.
module gcpf_queue
    import gcpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  gcpf_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output gcpf_item_t head_item
);

    gcpf_item_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/gcpf_back.sv @@
// Back end: packet framing state, word counting, irq flag and the output register.
// Depends on gcpf_pkg and the assertion macro header.
`include "gpu_command_packet_framer_macros.svh"

module gcpf_back
    import gcpf_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  gcpf_item_t head_item,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [87:0] m_tdata,
    output logic [2:0] m_tuser
);

    logic                  in_packet_reg, in_packet_next;
    logic [KIND_W-1:0]     open_kind_reg, open_kind_next;
    logic [COUNT_BITS-1:0] words_taken_reg, words_taken_next;
    logic [COUNT_BITS-1:0] words_total_reg, words_total_next;
    logic [2:0]            open_flags_reg, open_flags_next;
    logic                  irq_reg, irq_next;
    logic                  valid_reg, valid_next;
    logic [87:0]           data_reg, data_next;
    logic [2:0]            role_reg, role_next;

    logic [COUNT_BITS-1:0] total_eff;
    logic [COUNT_BITS:0]   n_plus1;
    logic [31:0]           n_ext;
    logic                  last;
    logic [2:0]            role;
    logic [KIND_W-1:0]     kind;
    logic [2:0]            flags;
    logic [IDX_W-1:0]      idx;
    logic [31:0]           data;
    logic [2:0]            et;
    logic [ENV_W-1:0]      ev;

    assign pop      = head_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = role_reg;

    always_comb
    begin
        in_packet_next   = in_packet_reg;
        open_kind_next   = open_kind_reg;
        words_taken_next = words_taken_reg;
        words_total_next = words_total_reg;
        open_flags_next  = open_flags_reg;
        irq_next         = irq_reg;
        role  = ROLE_SINGLE;
        kind  = KIND_NONE;
        flags = 3'd0;
        idx   = '0;
        data  = head_item.word;
        et    = 3'd0;
        ev    = '0;
        last  = 1'b0;
        n_ext = 32'(words_taken_reg);
        n_plus1 = {1'b0, words_taken_reg} + 1'b1;
        // the VRAM write length is known once word 2 is seen
        if (open_kind_reg == KIND_VRAM_WRITE && words_taken_reg == COUNT_BITS'(2))
            total_eff = COUNT_BITS'(head_item.vram_total);
        else
            total_eff = words_total_reg;

        if (head_item.action)
        begin
            in_packet_next   = 1'b0;
            open_kind_next   = KIND_NONE;
            words_taken_next = '0;
            words_total_next = '0;
            open_flags_next  = 3'd0;
            role = ROLE_RESET;
            data = 32'd0;
        end
        else if (!in_packet_reg)
        begin
            case (head_item.cls)
                CLS_PACKET:
                begin
                    in_packet_next   = 1'b1;
                    open_kind_next   = head_item.kind;
                    words_taken_next = COUNT_BITS'(1);
                    words_total_next = COUNT_BITS'(head_item.total);
                    open_flags_next  = head_item.flags;
                    role  = ROLE_PACKET;
                    kind  = head_item.kind;
                    flags = head_item.flags;
                end
                CLS_NOP:
                    role = ROLE_SINGLE;
                CLS_IRQ:
                    irq_next = 1'b1;
                CLS_ENV:
                begin
                    et = head_item.env_target;
                    ev = head_item.env_value;
                end
                default:
                    role = ROLE_INVALID;
            endcase
        end
        else
        begin
            kind  = open_kind_reg;
            flags = open_flags_reg;
            if (open_kind_reg == KIND_MONO_POLY || open_kind_reg == KIND_SHAD_POLY)
                last = (words_taken_reg >= COUNT_BITS'(3)) && head_item.line_end;
            else
                last = n_plus1 >= {1'b0, total_eff};
            words_total_next = total_eff;
            role = last ? ROLE_LAST : ROLE_PACKET;
            idx  = (n_ext > 32'(IDX_MAX)) ? IDX_MAX : n_ext[IDX_W-1:0];
            if (words_taken_reg != '1)
                words_taken_next = words_taken_reg + 1'b1;
            if (last)
            begin
                in_packet_next   = 1'b0;
                open_kind_next   = KIND_NONE;
                words_taken_next = '0;
                words_total_next = '0;
                open_flags_next  = 3'd0;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        role_next  = role_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            role_next  = role;
            data_next  = {irq_next, ev, et, data, idx, flags[2:1], flags[0], kind};
        end
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        role_reg <= role_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg   <= 1'b0;
            open_kind_reg   <= KIND_NONE;
            words_taken_reg <= '0;
            words_total_reg <= '0;
            open_flags_reg  <= 3'd0;
            irq_reg         <= 1'b0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                in_packet_reg   <= in_packet_next;
                open_kind_reg   <= open_kind_next;
                words_taken_reg <= words_taken_next;
                words_total_reg <= words_total_next;
                open_flags_reg  <= open_flags_next;
                irq_reg         <= irq_next;
            end
        end
    end

    `GCPF_ASSERT_NOW(a_idle_no_kind, !in_packet_reg, open_kind_reg == KIND_NONE,
        "idle framer holds a packet kind")
    `GCPF_ASSERT_NEXT(a_abort_closes, pop && head_item.action, !in_packet_reg,
        "fifo reset left a packet open")
    `GCPF_ASSERT_NOW(a_last_closed, valid_reg && role_reg == ROLE_LAST, !in_packet_reg,
        "packet still open after its last word")
    `GCPF_ASSERT_NEXT(a_irq_sticky, irq_reg, irq_reg, "irq flag dropped")

endmodule
